[sv/ilt_pkg.sv]
// ----------------------------------------------------------------------------
// ilt_pkg
// Shared types and constants for the IRC line tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ilt_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned IndexWidth = 4;
   localparam int unsigned KindWidth  = 2;

   localparam logic [CharWidth-1:0]  ColonChar     = 8'h3A;
   localparam logic [CharWidth-1:0]  SpaceChar     = 8'h20;
   localparam logic [IndexWidth-1:0] ParamIndexMax = 4'd15;

   typedef enum logic [KindWidth-1:0] {
      KindCmd   = 2'd0,
      KindMid   = 2'd1,
      KindTrail = 2'd2
   } kind_type;

   // parser phases, one-hot
   typedef enum logic [6:0] {
      PhStart    = 7'b000_0001,
      PhPrefix   = 7'b000_0010,
      PhPfxGap   = 7'b000_0100,
      PhCommand  = 7'b000_1000,
      PhParGap   = 7'b001_0000,
      PhMiddle   = 7'b010_0000,
      PhTrailing = 7'b100_0000
   } phase_type;

   typedef struct packed {
      logic [CharWidth-1:0]  out_char;
      logic                  has_char;
      kind_type              token_kind;
      logic [IndexWidth-1:0] param_index;
      logic                  token_end;
      logic                  line_end;
   } result_type;

endpackage

`default_nettype wire

[sv/irc_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// irc_line_tokenizer
// Splits an IRC line, one byte per transfer, into command and parameter bytes.
// ----------------------------------------------------------------------------
//  channel | direction | payload                                  | handshake
//  req_    | in        | line_byte, last_byte                     | valid/ready
//  rsp_    | out       | out_char, has_char, token_kind,          | valid/ready
//          |           | param_index, token_end, line_end         |
//
//  One byte is accepted per cycle while req_ready is high; the parser phase,
//  parameter count and result, if any, register at the accepting edge.
//  req_ready is low only while a held result is not taken.
//  Reset is synchronous and returns the parser to line start with an empty
//  result register.
// ----------------------------------------------------------------------------
`default_nettype none

module irc_line_tokenizer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire logic [ilt_pkg::CharWidth-1:0]    req_line_byte,
   input  wire logic                             req_last_byte,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      logic [ilt_pkg::CharWidth-1:0]    rsp_out_char,
   output      logic                             rsp_has_char,
   output      logic [ilt_pkg::KindWidth-1:0]    rsp_token_kind,
   output      logic [ilt_pkg::IndexWidth-1:0]   rsp_param_index,
   output      logic                             rsp_token_end,
   output      logic                             rsp_line_end
);

   ilt_pkg::phase_type               phase_ff, phase_in;
   logic [ilt_pkg::IndexWidth-1:0]   count_ff, count_in;
   logic                             rsp_valid_ff;
   ilt_pkg::result_type              result_ff, result_in;
   logic                             have;
   logic                             is_colon, is_space;
   logic                             req_accept;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign is_colon   = (req_line_byte == ilt_pkg::ColonChar);
   assign is_space   = (req_line_byte == ilt_pkg::SpaceChar);

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      have      = 1'b0;
      result_in = '0;
      result_in.line_end = req_last_byte;

      unique case (phase_ff)
         ilt_pkg::PhStart: begin
            if (is_colon) begin
               phase_in = ilt_pkg::PhPrefix;
            end else if (is_space) begin
               have = 1'b1;
               result_in.token_end = 1'b1;
               phase_in = ilt_pkg::PhParGap;
            end else begin
               have = 1'b1;
               result_in.out_char  = req_line_byte;
               result_in.has_char  = 1'b1;
               result_in.token_end = req_last_byte;
               phase_in = ilt_pkg::PhCommand;
            end
         end
         ilt_pkg::PhPrefix: begin
            if (is_space) begin
               phase_in = ilt_pkg::PhPfxGap;
               // prefix ending the line closes an empty command
               result_in.token_end = req_last_byte;
            end
         end
         ilt_pkg::PhPfxGap: begin
            if (is_space) begin
               result_in.token_end = req_last_byte;
            end else begin
               have = 1'b1;
               result_in.out_char  = req_line_byte;
               result_in.has_char  = 1'b1;
               result_in.token_end = req_last_byte;
               phase_in = ilt_pkg::PhCommand;
            end
         end
         ilt_pkg::PhCommand: begin
            have = 1'b1;
            if (is_space) begin
               result_in.token_end = 1'b1;
               phase_in = ilt_pkg::PhParGap;
            end else begin
               result_in.out_char  = req_line_byte;
               result_in.has_char  = 1'b1;
               result_in.token_end = req_last_byte;
            end
         end
         ilt_pkg::PhParGap: begin
            if (is_colon) begin
               phase_in = ilt_pkg::PhTrailing;
               if (req_last_byte) begin
                  result_in.token_kind  = ilt_pkg::KindTrail;
                  result_in.param_index = count_ff;
                  result_in.token_end   = 1'b1;
               end
            end else if (!is_space) begin
               have = 1'b1;
               result_in.out_char    = req_line_byte;
               result_in.has_char    = 1'b1;
               result_in.token_kind  = ilt_pkg::KindMid;
               result_in.param_index = count_ff;
               result_in.token_end   = req_last_byte;
               phase_in = ilt_pkg::PhMiddle;
            end
         end
         ilt_pkg::PhMiddle: begin
            have = 1'b1;
            result_in.token_kind  = ilt_pkg::KindMid;
            result_in.param_index = count_ff;
            if (is_space) begin
               result_in.token_end = 1'b1;
               if (count_ff != ilt_pkg::ParamIndexMax) begin
                  count_in = count_ff + 1'b1;
               end
               phase_in = ilt_pkg::PhParGap;
            end else begin
               result_in.out_char  = req_line_byte;
               result_in.has_char  = 1'b1;
               result_in.token_end = req_last_byte;
            end
         end
         ilt_pkg::PhTrailing: begin
            have = 1'b1;
            result_in.out_char    = req_line_byte;
            result_in.has_char    = 1'b1;
            result_in.token_kind  = ilt_pkg::KindTrail;
            result_in.param_index = count_ff;
            result_in.token_end   = req_last_byte;
         end
         default: begin
            phase_in = ilt_pkg::PhStart;
            count_in = '0;
         end
      endcase

      if (req_last_byte) begin
         have     = 1'b1;
         phase_in = ilt_pkg::PhStart;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ilt_pkg::PhStart;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= have;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && have) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = result_ff.out_char;
   assign rsp_has_char    = result_ff.has_char;
   assign rsp_token_kind  = result_ff.token_kind;
   assign rsp_param_index = result_ff.param_index;
   assign rsp_token_end   = result_ff.token_end;
   assign rsp_line_end    = result_ff.line_end;

endmodule

`default_nettype wire

[sv/ilt_checker.sv]
// ----------------------------------------------------------------------------
// ilt_checker
// Port-level checks for the IRC line tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ilt_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic [ilt_pkg::CharWidth-1:0]    req_line_byte,
   input wire logic                             req_last_byte,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [ilt_pkg::CharWidth-1:0]    rsp_out_char,
   input wire logic                             rsp_has_char,
   input wire logic [ilt_pkg::KindWidth-1:0]    rsp_token_kind,
   input wire logic [ilt_pkg::IndexWidth-1:0]   rsp_param_index,
   input wire logic                             rsp_token_end,
   input wire logic                             rsp_line_end
);

   // a result not taken stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char)
         && $stable(rsp_token_end) && $stable(rsp_line_end))
      else $error("result changed while stalled");

   // input only stalls behind a stalled result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a held result");

   // a result that is neither a byte nor a token close is the bare line end
   a_bare_line_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_char && !rsp_token_end |->
         rsp_line_end && rsp_out_char == '0 && rsp_token_kind == ilt_pkg::KindCmd
         && rsp_param_index == '0)
      else $error("malformed line-end result");

   a_cmd_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == ilt_pkg::KindCmd |-> rsp_param_index == '0)
      else $error("command token with non-zero index");

   a_no_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_char |-> rsp_out_char == '0)
      else $error("character shown without has_char");

endmodule

bind irc_line_tokenizer ilt_checker u_ilt_checker (.*);

`default_nettype wire

[test/irc_line_tokenizer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_line_tokenizer_tb
// Feeds IRC lines one byte per transfer, with random gaps on the byte side
// and random back-pressure on the token side. Each byte runs through a
// software parser kept in step with the block. Each token transfer is
// compared field by field with the oldest expected token.
// ----------------------------------------------------------------------------

module irc_line_tokenizer_tb;

   localparam int unsigned TotalBytes = 800;
   localparam int unsigned StallLimit = 2000;
   localparam int unsigned MaxReports = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid     = 1'b0;
   logic                           req_ready;
   logic [ilt_pkg::CharWidth-1:0]  req_line_byte = '0;
   logic                           req_last_byte = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready     = 1'b0;
   logic [ilt_pkg::CharWidth-1:0]  rsp_out_char;
   logic                           rsp_has_char;
   logic [ilt_pkg::KindWidth-1:0]  rsp_token_kind;
   logic [ilt_pkg::IndexWidth-1:0] rsp_param_index;
   logic                           rsp_token_end;
   logic                           rsp_line_end;

   // software copy of the parser
   ilt_pkg::phase_type             line_phase = ilt_pkg::PhStart;
   logic [ilt_pkg::IndexWidth-1:0] mid_count  = '0;

   ilt_pkg::result_type expected_tokens[$];
   int unsigned bytes_sent  = 0;
   int unsigned fail_count  = 0;
   bit          send_idle_on = 1'b1;
   bit          recv_stall_on = 1'b1;

   irc_line_tokenizer i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_line_byte   (req_line_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_has_char    (rsp_has_char),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_param_index (rsp_param_index),
      .rsp_token_end   (rsp_token_end),
      .rsp_line_end    (rsp_line_end)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Advances the parser by one byte; returns 1 if the byte yields a token
   // transfer, which is then placed in tok.
   function automatic bit predict_token(input logic [ilt_pkg::CharWidth-1:0] b,
                                        input logic last,
                                        output ilt_pkg::result_type tok);
      bit emit;
      emit = 1'b0;
      tok  = '0;
      case (line_phase)
         ilt_pkg::PhStart: begin
            if (b == ilt_pkg::ColonChar) begin
               line_phase = ilt_pkg::PhPrefix;
            end else if (b == ilt_pkg::SpaceChar) begin
               // empty command
               tok.token_kind = ilt_pkg::KindCmd;
               tok.token_end  = 1'b1;
               emit = 1'b1;
               line_phase = ilt_pkg::PhParGap;
            end else begin
               tok.out_char   = b;
               tok.has_char   = 1'b1;
               tok.token_kind = ilt_pkg::KindCmd;
               tok.token_end  = last;
               emit = 1'b1;
               line_phase = ilt_pkg::PhCommand;
            end
         end
         ilt_pkg::PhPrefix: begin
            if (b == ilt_pkg::SpaceChar) begin
               line_phase = ilt_pkg::PhPfxGap;
               if (last) begin
                  tok.token_kind = ilt_pkg::KindCmd;
                  tok.token_end  = 1'b1;
               end
            end
         end
         ilt_pkg::PhPfxGap: begin
            if (b == ilt_pkg::SpaceChar) begin
               if (last) begin
                  tok.token_kind = ilt_pkg::KindCmd;
                  tok.token_end  = 1'b1;
               end
            end else begin
               tok.out_char   = b;
               tok.has_char   = 1'b1;
               tok.token_kind = ilt_pkg::KindCmd;
               tok.token_end  = last;
               emit = 1'b1;
               line_phase = ilt_pkg::PhCommand;
            end
         end
         ilt_pkg::PhCommand: begin
            tok.token_kind = ilt_pkg::KindCmd;
            if (b == ilt_pkg::SpaceChar) begin
               tok.token_end = 1'b1;
               line_phase = ilt_pkg::PhParGap;
            end else begin
               tok.out_char  = b;
               tok.has_char  = 1'b1;
               tok.token_end = last;
            end
            emit = 1'b1;
         end
         ilt_pkg::PhParGap: begin
            if (b == ilt_pkg::ColonChar) begin
               line_phase = ilt_pkg::PhTrailing;
               if (last) begin
                  // empty trailing parameter
                  tok.token_kind  = ilt_pkg::KindTrail;
                  tok.param_index = mid_count;
                  tok.token_end   = 1'b1;
               end
            end else if (b != ilt_pkg::SpaceChar) begin
               tok.out_char    = b;
               tok.has_char    = 1'b1;
               tok.token_kind  = ilt_pkg::KindMid;
               tok.param_index = mid_count;
               tok.token_end   = last;
               emit = 1'b1;
               line_phase = ilt_pkg::PhMiddle;
            end
         end
         ilt_pkg::PhMiddle: begin
            tok.token_kind  = ilt_pkg::KindMid;
            tok.param_index = mid_count;
            if (b == ilt_pkg::SpaceChar) begin
               tok.token_end = 1'b1;
               if (mid_count < ilt_pkg::ParamIndexMax) mid_count = mid_count + 1'b1;
               line_phase = ilt_pkg::PhParGap;
            end else begin
               tok.out_char  = b;
               tok.has_char  = 1'b1;
               tok.token_end = last;
            end
            emit = 1'b1;
         end
         ilt_pkg::PhTrailing: begin
            tok.out_char    = b;
            tok.has_char    = 1'b1;
            tok.token_kind  = ilt_pkg::KindTrail;
            tok.param_index = mid_count;
            tok.token_end   = last;
            emit = 1'b1;
         end
         default: begin
            line_phase = ilt_pkg::PhStart;
            mid_count  = '0;
         end
      endcase
      if (last) begin
         emit = 1'b1;
         line_phase = ilt_pkg::PhStart;
         mid_count  = '0;
      end
      tok.line_end = last;
      return emit;
   endfunction

   function automatic string fmt_token(input ilt_pkg::result_type t);
      return $sformatf("char=%h has=%b kind=%0d idx=%0d end=%b line=%b",
                       t.out_char, t.has_char, t.token_kind, t.param_index,
                       t.token_end, t.line_end);
   endfunction

   function automatic int idle_gap();
      int r;
      if (!send_idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // random byte that does not end a token
   function automatic logic [ilt_pkg::CharWidth-1:0] word_byte(input bit no_colon);
      logic [ilt_pkg::CharWidth-1:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == ilt_pkg::SpaceChar || (no_colon && b == ilt_pkg::ColonChar));
      return b;
   endfunction

   function automatic logic [ilt_pkg::CharWidth-1:0] trail_byte();
      if ($urandom_range(0, 4) == 0) return ilt_pkg::SpaceChar;
      return 8'($urandom_range(0, 255));
   endfunction

   // Valid stays high after the transfer; it is lowered only before a gap.
   task automatic send_byte(input logic [ilt_pkg::CharWidth-1:0] b, input logic last);
      int                  gap;
      ilt_pkg::result_type tok;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_line_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (predict_token(b, last, tok)) expected_tokens = {expected_tokens, tok};
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   task automatic send_line_bytes(input logic [ilt_pkg::CharWidth-1:0] line[$]);
      for (int i = 0; i < line.size(); i++) send_byte(line[i], i == line.size() - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_tokens.size() != 0);
   endtask

   // Well-formed line with random content: optional prefix, command, middle
   // parameters, optional trailing parameter or trailing spaces.
   task automatic send_random_line(input int min_mid, input int max_mid);
      logic [ilt_pkg::CharWidth-1:0] line[$];
      int                            n_mid;
      if ($urandom_range(0, 3) == 0) begin
         line = {line, ilt_pkg::ColonChar};
         repeat ($urandom_range(0, 5)) line = {line, word_byte(1'b0)};
         repeat ($urandom_range(1, 3)) line = {line, ilt_pkg::SpaceChar};
      end else if ($urandom_range(0, 15) == 0) begin
         line = {line, ilt_pkg::SpaceChar};
      end
      repeat ($urandom_range(1, 6)) line = {line, word_byte(1'b0)};
      n_mid = $urandom_range(min_mid, max_mid);
      repeat (n_mid) begin
         repeat ($urandom_range(1, 3)) line = {line, ilt_pkg::SpaceChar};
         line = {line, word_byte(1'b1)};
         repeat ($urandom_range(0, 4)) line = {line, word_byte(1'b0)};
      end
      if ($urandom_range(0, 1) == 0) begin
         repeat ($urandom_range(1, 2)) line = {line, ilt_pkg::SpaceChar};
         line = {line, ilt_pkg::ColonChar};
         repeat ($urandom_range(0, 8)) line = {line, trail_byte()};
      end else if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 3)) line = {line, ilt_pkg::SpaceChar};
      end
      send_line_bytes(line);
   endtask

   task automatic test_prefix_handling();
      send_text(":p");      // prefix only
      send_text(": ");      // prefix closed by the last byte
      send_text(":x  B");   // space run after prefix
   endtask

   task automatic test_empty_tokens();
      send_text(" ");       // empty command on its own
      send_text("A :");     // empty trailing
      send_text("A b  ");   // line ends in spaces
   endtask

   task automatic test_byte_extremes();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(ilt_pkg::SpaceChar, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(ilt_pkg::ColonChar, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_param_saturation();
      repeat (4) send_random_line(15, 20);
   endtask

   task automatic test_random_lines();
      logic [ilt_pkg::CharWidth-1:0] line[$];
      int unsigned                   n_lines;
      n_lines = 0;
      while (bytes_sent < TotalBytes) begin
         if (n_lines % 12 == 0) begin
            send_idle_on  = ($urandom_range(0, 3) != 0);
            recv_stall_on = ($urandom_range(0, 3) != 0);
         end
         if (n_lines % 30 == 29) wait_drained();
         if ($urandom_range(0, 6) == 0) begin
            // noise: arbitrary bytes, colons and spaces in any order
            line.delete();
            repeat ($urandom_range(1, 12)) begin
               case ($urandom_range(0, 6))
                  0, 1:    line = {line, ilt_pkg::SpaceChar};
                  2:       line = {line, ilt_pkg::ColonChar};
                  default: line = {line, 8'($urandom_range(0, 255))};
               endcase
            end
            send_line_bytes(line);
         end else begin
            send_random_line(0, ($urandom_range(0, 9) == 0) ? 18 : 5);
         end
         n_lines++;
      end
      send_idle_on  = 1'b1;
      recv_stall_on = 1'b1;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_prefix_handling();
      test_empty_tokens();
      test_byte_extremes();
      test_param_saturation();
      test_random_lines();
      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // token side: checking, back-pressure and watchdog
   initial begin : token_monitor
      ilt_pkg::result_type got;
      ilt_pkg::result_type want;
      int unsigned         stall_left;
      int unsigned         quiet_cycles;
      bit                  moved;
      stall_left   = 0;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         moved = !reset && ((req_valid && req_ready) || (rsp_valid && rsp_ready));
         if (!reset && rsp_valid && rsp_ready) begin
            got.out_char    = rsp_out_char;
            got.has_char    = rsp_has_char;
            got.token_kind  = ilt_pkg::kind_type'(rsp_token_kind);
            got.param_index = rsp_param_index;
            got.token_end   = rsp_token_end;
            got.line_end    = rsp_line_end;
            if (expected_tokens.size() == 0) begin
               fail_count++;
               if (fail_count <= MaxReports)
                  $display("%0t: unexpected token transfer: expected none, actual %s",
                           $time, fmt_token(got));
            end else begin
               want = expected_tokens.pop_front();
               if (got.out_char !== want.out_char || got.has_char !== want.has_char ||
                   got.token_kind !== want.token_kind ||
                   got.param_index !== want.param_index ||
                   got.token_end !== want.token_end || got.line_end !== want.line_end) begin
                  fail_count++;
                  if (fail_count <= MaxReports)
                     $display("%0t: token mismatch: expected %s, actual %s",
                              $time, fmt_token(want), fmt_token(got));
               end
            end
         end

         if (recv_stall_on && stall_left == 0 && $urandom_range(0, 4) == 0)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end

         if (moved) quiet_cycles = 0;
         else       quiet_cycles++;
         if (quiet_cycles >= StallLimit) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

endmodule
